### design/rabxf_pkg.sv
package rabxf_pkg;

	// Defaults for the top-level parameters.
	localparam int CHANNELS_DEF    = 2;
	localparam int SAMPLE_BITS_DEF = 24;

	// Fixed field widths.
	localparam int POS_W     = 41;
	localparam int LEN_W     = 40;
	localparam int GAIN_W    = 18;
	localparam int STEP_W    = 17;
	localparam int Q16_W     = 17;
	localparam int FRAC_BITS = 16;

	localparam logic [Q16_W-1:0] ONE_Q16    = 17'h10000;
	localparam int               ROUND_HALF = 32768;

	// Multiplier digit size in bits per cycle.
	localparam int MUL_DIGIT = 2;

	// Configuration port.
	localparam int APB_DATA_W = 64;
	localparam int PADDR_W    = 5;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_A_GAIN      = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_B_GAIN      = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FADE_STEP   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SONG_LENGTH = 2'd3;

	localparam logic [GAIN_W-1:0] A_GAIN_RST      = 18'd65536;
	localparam logic [GAIN_W-1:0] B_GAIN_RST      = 18'd65536;
	localparam logic [STEP_W-1:0] FADE_STEP_RST   = 17'd273;
	localparam logic [LEN_W-1:0]  SONG_LENGTH_RST = 40'd0;

	typedef struct packed {
		logic [GAIN_W-1:0] a_gain;
		logic [GAIN_W-1:0] b_gain;
		logic [STEP_W-1:0] fade_step;
		logic [LEN_W-1:0]  song_length;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

### design/rabxf_if.sv
interface rabxf_in_if #(
	parameter int SAMPLE_BITS = rabxf_pkg::SAMPLE_BITS_DEF
) ();
	logic                                valid;
	logic                                ready;
	logic signed [rabxf_pkg::POS_W-1:0]  source_position;
	logic                                select_reference;
	logic signed [SAMPLE_BITS-1:0]       live_left;
	logic signed [SAMPLE_BITS-1:0]       live_right;
	logic signed [SAMPLE_BITS-1:0]       reference_left;
	logic signed [SAMPLE_BITS-1:0]       reference_right;

	modport source (
		output valid, source_position, select_reference,
		output live_left, live_right, reference_left, reference_right,
		input  ready
	);
	modport sink (
		input  valid, source_position, select_reference,
		input  live_left, live_right, reference_left, reference_right,
		output ready
	);
endinterface

interface rabxf_out_if #(
	parameter int SAMPLE_BITS = rabxf_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic                          locked;

	modport source (
		output valid, out_left, out_right, locked,
		input  ready
	);
	modport sink (
		input  valid, out_left, out_right, locked,
		output ready
	);
endinterface

### design/rabxf_regs.sv
module rabxf_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rabxf_pkg::PADDR_W-1:0]        paddr,
	input  logic [rabxf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [rabxf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready,
	output rabxf_pkg::cfg_t                      cfg
);

	rabxf_pkg::cfg_t                   cfg_q;
	logic [rabxf_pkg::REG_IDX_W-1:0]   idx;
	logic                              wr_en;

	// Registers sit on 8-byte boundaries; the low address bits are ignored.
	assign idx   = paddr[rabxf_pkg::PADDR_W-1:3];
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_gain      <= rabxf_pkg::A_GAIN_RST;
			cfg_q.b_gain      <= rabxf_pkg::B_GAIN_RST;
			cfg_q.fade_step   <= rabxf_pkg::FADE_STEP_RST;
			cfg_q.song_length <= rabxf_pkg::SONG_LENGTH_RST;
		end else if (wr_en) begin
			case (idx)
				rabxf_pkg::REG_A_GAIN: begin
					cfg_q.a_gain <= pwdata[rabxf_pkg::GAIN_W-1:0];
				end
				rabxf_pkg::REG_B_GAIN: begin
					cfg_q.b_gain <= pwdata[rabxf_pkg::GAIN_W-1:0];
				end
				rabxf_pkg::REG_FADE_STEP: begin
					cfg_q.fade_step <= pwdata[rabxf_pkg::STEP_W-1:0];
				end
				rabxf_pkg::REG_SONG_LENGTH: begin
					cfg_q.song_length <= pwdata[rabxf_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			rabxf_pkg::REG_A_GAIN:      prdata = rabxf_pkg::APB_DATA_W'(cfg_q.a_gain);
			rabxf_pkg::REG_B_GAIN:      prdata = rabxf_pkg::APB_DATA_W'(cfg_q.b_gain);
			rabxf_pkg::REG_FADE_STEP:   prdata = rabxf_pkg::APB_DATA_W'(cfg_q.fade_step);
			rabxf_pkg::REG_SONG_LENGTH: prdata = rabxf_pkg::APB_DATA_W'(cfg_q.song_length);
			default:                    prdata = '0;
		endcase
	end

endmodule

### design/rabxf_mul.sv
module rabxf_mul #(
	parameter int MC_W = 43,
	parameter int MR_W = 18
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [MC_W-1:0]          mc,
	input  logic [MR_W-1:0]                 mr,
	output logic signed [MC_W+MR_W-1:0]     prod,
	output rabxf_pkg::mul_stat_t            stat
);

	localparam int ACC_W = MC_W + MR_W;
	localparam int DIGIT = rabxf_pkg::MUL_DIGIT;
	localparam int STEPS = (MR_W + DIGIT - 1) / DIGIT;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [ACC_W-1:0] mc_q;
	logic [MR_W-1:0]         mr_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] pp;

	// Partial product of the shifted multiplicand and the low digit of the multiplier.
	always_comb begin
		pp = '0;
		for (int j = 0; j < DIGIT; j++) begin
			if (mr_q[j]) begin
				pp = pp + (mc_q <<< j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q  <= ACC_W'(mc);
			mr_q  <= mr;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp;
			mc_q  <= mc_q <<< DIGIT;
			mr_q  <= mr_q >> DIGIT;
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### design/ramped_ab_crossfader_unit.sv
// Ramped A/B crossfader. Each request on frame_in carries one frame: its song
// position, the select-reference flag and one live (A) and one reference (B)
// sample per channel. Each frame produces exactly one request on frame_out with
// the mixed samples and the locked flag.
// The block works on one frame at a time. A shared multiplier takes two
// multiplier bits per cycle; a frame needs two products for the taper and
// blend plus three per channel. A new frame is taken only after the result
// of the last one has been loaded into the output register.
// frame_in.ready is high whenever the sequencer is idle, also while a finished
// result still waits in the output register. If frame_out stalls, the next
// frame is computed and then held until the output register is free.
// The user writes configuration through the APB port only while no frame is
// in flight; the block itself does not enforce this. Reset (arst_n low)
// returns the configuration registers to their defaults, clears the blend
// level to zero and drops all valids.
module ramped_ab_crossfader_unit #(
	parameter int CHANNELS    = rabxf_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = rabxf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rabxf_pkg::PADDR_W-1:0]      paddr,
	input  logic [rabxf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rabxf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                               pready,
	rabxf_in_if.sink                           frame_in,
	rabxf_out_if.source                        frame_out
);

	localparam int LA_W     = SAMPLE_BITS + rabxf_pkg::GAIN_W;
	localparam int MC_W     = LA_W + 1;
	localparam int ACC_W    = MC_W + rabxf_pkg::GAIN_W;
	localparam int MIX_W    = LA_W + 1;
	localparam int QW       = MIX_W - rabxf_pkg::FRAC_BITS;
	localparam int CH_CNT_W = $clog2(CHANNELS + 1);
	localparam int Q16_W    = rabxf_pkg::Q16_W;
	localparam int LEN_W    = rabxf_pkg::LEN_W;
	localparam int FB       = rabxf_pkg::FRAC_BITS;

	localparam logic [Q16_W-1:0] ONE = rabxf_pkg::ONE_Q16;
	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_PREP    = 14'b00000000000010,
		S_EDGE    = 14'b00000000000100,
		S_TAPER_W = 14'b00000000001000,
		S_BLEND   = 14'b00000000010000,
		S_BLEND_W = 14'b00000000100000,
		S_LIVE    = 14'b00000001000000,
		S_LIVE_W  = 14'b00000010000000,
		S_REF     = 14'b00000100000000,
		S_REF_W   = 14'b00001000000000,
		S_DIFF    = 14'b00010000000000,
		S_DIFF_W  = 14'b00100000000000,
		S_ROUND   = 14'b01000000000000,
		S_DONE    = 14'b10000000000000
	} state_t;

	state_t state_q;

	rabxf_pkg::cfg_t      cfg;
	rabxf_pkg::mul_stat_t mul_stat;

	logic                            mul_start;
	logic signed [MC_W-1:0]          mul_mc;
	logic [rabxf_pkg::GAIN_W-1:0]    mul_mr;
	logic signed [ACC_W-1:0]         mul_prod;

	// Frame payload and working registers.
	logic signed [rabxf_pkg::POS_W-1:0] pos_q;
	logic                               sel_q;
	logic signed [SAMPLE_BITS-1:0]      live_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0]      ref_q  [CHANNELS];
	logic signed [SAMPLE_BITS-1:0]      res_q  [CHANNELS];
	logic                               in_range_q;
	logic [Q16_W-1:0]                   step_q;
	logic [LEN_W-1:0]                   head_q;
	logic [LEN_W-1:0]                   tail_q;
	logic                               taper_zero_q;
	logic                               taper_full_q;
	logic [Q16_W-1:0]                   taper_q;
	logic [Q16_W-1:0]                   blend_q;
	logic [Q16_W-1:0]                   blend_level_q;
	logic signed [LA_W-1:0]             la_q;
	logic signed [LA_W-1:0]             rb_q;
	logic signed [MIX_W-1:0]            mix_q;
	logic [CH_CNT_W-1:0]                chan_left_q;

	// Output register.
	logic                               out_valid_q;
	logic signed [SAMPLE_BITS-1:0]      out_left_q;
	logic signed [SAMPLE_BITS-1:0]      out_right_q;
	logic                               locked_q;

	// Combinational helpers.
	logic [LEN_W-1:0]                   edge_dist;
	logic [Q16_W-1:0]                   blend_level_nx;
	logic                               taper_over;
	logic [Q16_W-1:0]                   taper_nx;
	logic signed [MIX_W-1:0]            rnd;
	logic [QW-1:0]                      rnd_q;
	logic [QW-SAMPLE_BITS:0]            rnd_top;
	logic signed [SAMPLE_BITS-1:0]      sat_val;
	logic                               out_free;

	rabxf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rabxf_mul #(
		.MC_W (MC_W),
		.MR_W (rabxf_pkg::GAIN_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mc     (mul_mc),
		.mr     (mul_mr),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	assign frame_in.ready = (state_q == S_IDLE);
	assign out_free       = !out_valid_q || frame_out.ready;

	// Distance to the nearer song edge, counted in frames from one.
	assign edge_dist = (head_q < tail_q) ? head_q : tail_q;

	// The blend level moves by one step toward its target and stops on it.
	always_comb begin
		if (in_range_q && sel_q) begin
			if ((ONE - blend_level_q) < step_q) begin
				blend_level_nx = ONE;
			end else begin
				blend_level_nx = blend_level_q + step_q;
			end
		end else begin
			if (blend_level_q < step_q) begin
				blend_level_nx = '0;
			end else begin
				blend_level_nx = blend_level_q - step_q;
			end
		end
	end

	// Taper saturates at unity once the edge distance times the step passes it.
	assign taper_over = (|mul_prod[ACC_W-1:Q16_W]) || (mul_prod[Q16_W-1:0] > ONE);
	always_comb begin
		if (taper_zero_q) begin
			taper_nx = '0;
		end else if (taper_full_q || taper_over) begin
			taper_nx = ONE;
		end else begin
			taper_nx = mul_prod[Q16_W-1:0];
		end
	end

	// Round half up, drop the fraction and clamp to the sample range.
	assign rnd     = mix_q + MIX_W'(rabxf_pkg::ROUND_HALF);
	assign rnd_q   = rnd[MIX_W-1:FB];
	assign rnd_top = rnd_q[QW-1:SAMPLE_BITS-1];
	always_comb begin
		if ((&rnd_top) || !(|rnd_top)) begin
			sat_val = rnd_q[SAMPLE_BITS-1:0];
		end else if (rnd_q[QW-1]) begin
			sat_val = SMIN;
		end else begin
			sat_val = SMAX;
		end
	end

	// Operands for the shared multiplier, chosen by the sequencer.
	always_comb begin
		mul_start = 1'b0;
		mul_mc    = '0;
		mul_mr    = '0;
		case (state_q)
			S_EDGE: begin
				mul_start = 1'b1;
				mul_mc    = MC_W'(edge_dist[FB-1:0]);
				mul_mr    = rabxf_pkg::GAIN_W'(step_q);
			end
			S_BLEND: begin
				mul_start = 1'b1;
				mul_mc    = MC_W'(blend_level_q);
				mul_mr    = rabxf_pkg::GAIN_W'(taper_q);
			end
			S_LIVE: begin
				mul_start = 1'b1;
				mul_mc    = MC_W'(live_q[0]);
				mul_mr    = cfg.a_gain;
			end
			S_REF: begin
				mul_start = 1'b1;
				mul_mc    = MC_W'(ref_q[0]);
				mul_mr    = cfg.b_gain;
			end
			S_DIFF: begin
				mul_start = 1'b1;
				mul_mc    = MC_W'(rb_q) - MC_W'(la_q);
				mul_mr    = rabxf_pkg::GAIN_W'(blend_q);
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			blend_level_q <= '0;
			chan_left_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// A result loaded in the done state keeps the valid set instead.
			if (out_valid_q && frame_out.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (frame_in.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					blend_level_q <= blend_level_nx;
					state_q       <= S_TAPER_W;
				end
				S_TAPER_W: begin
					if (mul_stat.done) begin
						state_q <= S_BLEND;
					end
				end
				S_BLEND: begin
					state_q <= S_BLEND_W;
				end
				S_BLEND_W: begin
					if (mul_stat.done) begin
						chan_left_q <= CH_CNT_W'(CHANNELS);
						state_q     <= S_LIVE;
					end
				end
				S_LIVE: begin
					state_q <= S_LIVE_W;
				end
				S_LIVE_W: begin
					if (mul_stat.done) begin
						state_q <= S_REF;
					end
				end
				S_REF: begin
					state_q <= S_REF_W;
				end
				S_REF_W: begin
					if (mul_stat.done) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q <= S_DIFF_W;
				end
				S_DIFF_W: begin
					if (mul_stat.done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					chan_left_q <= chan_left_q - CH_CNT_W'(1);
					if (chan_left_q == CH_CNT_W'(1)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LIVE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; they follow the sequencer and need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (frame_in.valid) begin
					pos_q     <= frame_in.source_position;
					sel_q     <= frame_in.select_reference;
					live_q[0] <= frame_in.live_left;
					ref_q[0]  <= frame_in.reference_left;
					if (CHANNELS > 1) begin
						live_q[CHANNELS-1] <= frame_in.live_right;
						ref_q[CHANNELS-1]  <= frame_in.reference_right;
					end
				end
			end
			S_PREP: begin
				in_range_q <= !pos_q[rabxf_pkg::POS_W-1] &&
					(pos_q[LEN_W-1:0] < cfg.song_length);
				if (cfg.fade_step == '0) begin
					step_q <= Q16_W'(1);
				end else if (cfg.fade_step > ONE) begin
					step_q <= ONE;
				end else begin
					step_q <= cfg.fade_step;
				end
				head_q <= pos_q[LEN_W-1:0] + LEN_W'(1);
				tail_q <= cfg.song_length - pos_q[LEN_W-1:0];
			end
			S_EDGE: begin
				taper_zero_q <= !in_range_q;
				taper_full_q <= |edge_dist[LEN_W-1:FB];
			end
			S_TAPER_W: begin
				if (mul_stat.done) begin
					taper_q <= taper_nx;
				end
			end
			S_BLEND_W: begin
				if (mul_stat.done) begin
					blend_q <= mul_prod[FB +: Q16_W];
				end
			end
			S_LIVE_W: begin
				if (mul_stat.done) begin
					la_q <= mul_prod[LA_W-1:0];
				end
			end
			S_REF_W: begin
				if (mul_stat.done) begin
					rb_q <= mul_prod[LA_W-1:0];
				end
			end
			S_DIFF_W: begin
				if (mul_stat.done) begin
					mix_q <= MIX_W'(la_q) + mul_prod[FB +: MIX_W];
				end
			end
			S_ROUND: begin
				// Channels pass through the lanes as a shift line.
				for (int i = 0; i < CHANNELS - 1; i++) begin
					live_q[i] <= live_q[i+1];
					ref_q[i]  <= ref_q[i+1];
					res_q[i]  <= res_q[i+1];
				end
				res_q[CHANNELS-1] <= sat_val;
			end
			S_DONE: begin
				if (out_free) begin
					out_left_q  <= res_q[0];
					out_right_q <= (CHANNELS > 1) ? res_q[CHANNELS-1] : '0;
					locked_q    <= in_range_q &&
						((!sel_q && blend_q == '0) || (sel_q && blend_q == ONE));
				end
			end
			default: begin
			end
		endcase
	end

	assign frame_out.valid     = out_valid_q;
	assign frame_out.out_left  = out_left_q;
	assign frame_out.out_right = out_right_q;
	assign frame_out.locked    = locked_q;

`ifndef ASSERT_OFF
	a_blend_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		blend_level_q <= ONE)
		else $error("blend level above unity");

	a_blend_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EDGE) |=> $stable(blend_level_q))
		else $error("blend level changed outside its update step");

	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == S_TAPER_W || state_q == S_BLEND_W ||
			state_q == S_LIVE_W || state_q == S_REF_W || state_q == S_DIFF_W))
		else $error("multiplier finished while nobody waited");

	a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mul_stat.busy)
		else $error("multiplier busy while idle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_in.valid && frame_in.ready) |=> (state_q == S_PREP))
		else $error("accepted frame did not start processing");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking testbench for the ramped A/B crossfader.
// Every frame accepted on frame_in goes through a local model of the
// crossfade datapath, and the predicted output request is queued. Each output
// request is then checked against the oldest prediction, field by field.
module testbench;

	localparam int SB = rabxf_pkg::SAMPLE_BITS_DEF;
	localparam int CH = rabxf_pkg::CHANNELS_DEF;

	localparam int POS_W      = rabxf_pkg::POS_W;
	localparam int LEN_W      = rabxf_pkg::LEN_W;
	localparam int Q16_W      = rabxf_pkg::Q16_W;
	localparam int GAIN_W     = rabxf_pkg::GAIN_W;
	localparam int STEP_W     = rabxf_pkg::STEP_W;
	localparam int PADDR_W    = rabxf_pkg::PADDR_W;
	localparam int APB_DATA_W = rabxf_pkg::APB_DATA_W;
	localparam int REG_IDX_W  = rabxf_pkg::REG_IDX_W;
	localparam int ROUND_HALF = rabxf_pkg::ROUND_HALF;

	// Time the unit needs for one frame, in cycles.
	localparam int FRAME_CYCLES = 25 + 34 * CH;
	localparam int HOLD_CYCLES  = 800;

	// About 1250 frames, plus stalls, stay far below this bound even with the
	// slowest receiver.
	localparam longint CYCLE_LIMIT = 2000000;

	localparam longint ONE      = 65536;
	localparam longint POS_MAX  = (64'sd1 <<< (POS_W - 1)) - 1;
	localparam longint POS_MIN  = -(64'sd1 <<< (POS_W - 1));
	localparam longint LEN_MAX  = (64'sd1 <<< LEN_W) - 1;
	localparam longint OUT_MAX  = (64'sd1 <<< (SB - 1)) - 1;
	localparam longint OUT_MIN  = -(64'sd1 <<< (SB - 1));

	localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

	typedef struct {
		logic signed [POS_W-1:0] pos;
		logic                    sel;
		logic signed [SB-1:0]    live_l;
		logic signed [SB-1:0]    live_r;
		logic signed [SB-1:0]    ref_l;
		logic signed [SB-1:0]    ref_r;
	} frame_t;

	typedef struct {
		logic signed [SB-1:0] out_left;
		logic signed [SB-1:0] out_right;
		logic                 locked;
	} mix_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	rabxf_in_if  #(.SAMPLE_BITS(SB)) frame_in_if ();
	rabxf_out_if #(.SAMPLE_BITS(SB)) frame_out_if ();

	ramped_ab_crossfader_unit #(
		.CHANNELS    (CH),
		.SAMPLE_BITS (SB)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.frame_in  (frame_in_if),
		.frame_out (frame_out_if)
	);

	always #5 clk = ~clk;

	// Local copy of the mixer registers and of the blend level. The registers
	// are only changed while no frame is in flight, so the copy is updated
	// right at the write.
	rabxf_pkg::cfg_t   mixer_cfg;
	logic [Q16_W-1:0]  blend_level;
	mix_result_t       expected_mix_q[$];

	int     error_count     = 0;
	int     frames_accepted = 0;
	int     results_checked = 0;
	int     locked_seen     = 0;
	int     settings_used   = 0;
	int     send_idle_pct   = 0;
	int     recv_stall_pct  = 0;
	longint cycle_count     = 0;
	logic   output_held     = 1'b0;
	event   start_hold;

	frame_t      seen_frame;
	mix_result_t want;

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= 100) begin
			$display("[%0t] MISMATCH: %s", $time, msg);
		end
	endtask

	// One channel of the mix. Both products carry a 2^16 scale; the blend pulls
	// the gained live sample toward the gained reference, and the sum is
	// rounded half up and clamped to the sample width.
	function automatic logic signed [SB-1:0] mix_sample(logic signed [SB-1:0] live,
			logic signed [SB-1:0] refv, longint blend);
		longint la;
		longint rb;
		longint mix;
		longint res;
		la  = longint'(live) * longint'(mixer_cfg.a_gain);
		rb  = longint'(refv) * longint'(mixer_cfg.b_gain);
		mix = la + (((rb - la) * blend) >>> 16);
		res = (mix + ROUND_HALF) >>> 16;
		if (res > OUT_MAX) res = OUT_MAX;
		if (res < OUT_MIN) res = OUT_MIN;
		return res[SB-1:0];
	endfunction

	// Advances the blend level by one frame and returns the expected output.
	function automatic mix_result_t predict_crossfade(frame_t f);
		longint      step;
		longint      pos;
		longint      len;
		longint      level;
		longint      target;
		longint      edge_len;
		longint      taper;
		longint      blend;
		logic        in_range;
		mix_result_t r;
		// A zero step behaves as the smallest step, and anything above one
		// whole unit behaves as one unit.
		step = mixer_cfg.fade_step;
		if (step == 0) step = 1;
		if (step > ONE) step = ONE;
		pos = f.pos;
		len = mixer_cfg.song_length;
		// An empty song has no frame in range at all.
		in_range = (pos >= 0) && (pos < len);
		target   = (in_range && f.sel) ? ONE : 0;
		level    = blend_level;
		if (target > level) begin
			level = (target - level < step) ? target : level + step;
		end else if (target < level) begin
			level = (level - target < step) ? target : level - step;
		end
		blend_level = level[Q16_W-1:0];
		// The taper rises by one step per frame from either end of the song.
		taper = 0;
		if (in_range) begin
			edge_len = (pos + 1 < len - pos) ? pos + 1 : len - pos;
			taper    = (edge_len >= ONE) ? ONE : edge_len * step;
			if (taper > ONE) taper = ONE;
		end
		blend = (level * taper) >>> 16;
		r.out_left  = mix_sample(f.live_l, f.ref_l, blend);
		r.out_right = (CH >= 2) ? mix_sample(f.live_r, f.ref_r, blend) : '0;
		r.locked    = in_range && ((!f.sel && blend == 0) || (f.sel && blend == ONE));
		return r;
	endfunction

	// Every accepted request is predicted at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && frame_in_if.valid && frame_in_if.ready) begin
			seen_frame.pos    = frame_in_if.source_position;
			seen_frame.sel    = frame_in_if.select_reference;
			seen_frame.live_l = frame_in_if.live_left;
			seen_frame.live_r = frame_in_if.live_right;
			seen_frame.ref_l  = frame_in_if.reference_left;
			seen_frame.ref_r  = frame_in_if.reference_right;
			expected_mix_q.push_back(predict_crossfade(seen_frame));
			frames_accepted++;
		end
	end

	// Every output request is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && frame_out_if.valid && frame_out_if.ready) begin
			if (expected_mix_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result left=%0d right=%0d locked=%0b",
					frame_out_if.out_left, frame_out_if.out_right, frame_out_if.locked));
			end else begin
				want = expected_mix_q.pop_front();
				if (frame_out_if.out_left !== want.out_left)
					report_mismatch($sformatf("result %0d out_left=%0d, expected %0d",
						results_checked, frame_out_if.out_left, want.out_left));
				if (frame_out_if.out_right !== want.out_right)
					report_mismatch($sformatf("result %0d out_right=%0d, expected %0d",
						results_checked, frame_out_if.out_right, want.out_right));
				if (frame_out_if.locked !== want.locked)
					report_mismatch($sformatf("result %0d locked=%0b, expected %0b",
						results_checked, frame_out_if.locked, want.locked));
				if (want.locked) locked_seen++;
				results_checked++;
			end
		end
	end

	// Long receiver hold-off, counted here so the sender keeps running.
	initial forever begin
		@(start_hold);
		output_held = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		output_held = 1'b0;
	end

	// Output side: ready drops at random, and always while a hold-off runs.
	initial begin
		frame_out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			frame_out_if.ready = !output_held && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d requests still expected",
			cycle_count, expected_mix_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			rabxf_pkg::REG_A_GAIN:      mixer_cfg.a_gain      = value[GAIN_W-1:0];
			rabxf_pkg::REG_B_GAIN:      mixer_cfg.b_gain      = value[GAIN_W-1:0];
			rabxf_pkg::REG_FADE_STEP:   mixer_cfg.fade_step   = value[STEP_W-1:0];
			rabxf_pkg::REG_SONG_LENGTH: mixer_cfg.song_length = value[LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic read_register(input logic [REG_IDX_W-1:0] idx,
			output logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {idx, 3'b000};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [APB_DATA_W-1:0] register_value(logic [REG_IDX_W-1:0] idx);
		logic [APB_DATA_W-1:0] v;
		v = '0;
		case (idx)
			rabxf_pkg::REG_A_GAIN:      v = APB_DATA_W'(mixer_cfg.a_gain);
			rabxf_pkg::REG_B_GAIN:      v = APB_DATA_W'(mixer_cfg.b_gain);
			rabxf_pkg::REG_FADE_STEP:   v = APB_DATA_W'(mixer_cfg.fade_step);
			rabxf_pkg::REG_SONG_LENGTH: v = APB_DATA_W'(mixer_cfg.song_length);
			default: ;
		endcase
		return v;
	endfunction

	// Stops offering frames and waits until every predicted request has come
	// back, which leaves the unit idle.
	task automatic wait_for_results();
		@(negedge clk);
		frame_in_if.valid = 1'b0;
		while (expected_mix_q.size() != 0) @(negedge clk);
	endtask

	task automatic set_mixer(logic [GAIN_W-1:0] a, logic [GAIN_W-1:0] b,
			logic [STEP_W-1:0] step, logic [LEN_W-1:0] len);
		wait_for_results();
		write_register(rabxf_pkg::REG_A_GAIN, APB_DATA_W'(a));
		write_register(rabxf_pkg::REG_B_GAIN, APB_DATA_W'(b));
		write_register(rabxf_pkg::REG_FADE_STEP, APB_DATA_W'(step));
		write_register(rabxf_pkg::REG_SONG_LENGTH, APB_DATA_W'(len));
		settings_used++;
	endtask

	// Offers one frame, with random idle cycles ahead of it, and returns at the
	// edge that accepts it. Valid stays high into the next call.
	task automatic send_frame(frame_t f);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			frame_in_if.valid = 1'b0;
			@(negedge clk);
		end
		frame_in_if.valid            = 1'b1;
		frame_in_if.source_position  = f.pos;
		frame_in_if.select_reference = f.sel;
		frame_in_if.live_left        = f.live_l;
		frame_in_if.live_right       = f.live_r;
		frame_in_if.reference_left   = f.ref_l;
		frame_in_if.reference_right  = f.ref_r;
		do @(posedge clk); while (!frame_in_if.ready);
	endtask

	function automatic frame_t make_frame(longint pos, logic sel, logic signed [SB-1:0] ll,
			logic signed [SB-1:0] lr, logic signed [SB-1:0] rl, logic signed [SB-1:0] rr);
		frame_t f;
		f.pos    = pos[POS_W-1:0];
		f.sel    = sel;
		f.live_l = ll;
		f.live_r = lr;
		f.ref_l  = rl;
		f.ref_r  = rr;
		return f;
	endfunction

	// Random sample with the full-scale values and zero showing up often.
	function automatic logic signed [SB-1:0] random_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			default: return SB'($urandom());
		endcase
	endfunction

	function automatic frame_t random_frame(longint pos, logic sel);
		return make_frame(pos, sel, random_sample(), random_sample(),
			random_sample(), random_sample());
	endfunction

	function automatic logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 18'd65536;
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	// Where a run of consecutive frames starts: just before the song, near
	// its end, or anywhere inside it.
	function automatic longint burst_start();
		longint len;
		len = mixer_cfg.song_length;
		case ($urandom_range(3))
			0: return -longint'($urandom_range(0, 12));
			1: return len - longint'($urandom_range(0, 40));
			default: begin
				if (len == 0) return $urandom_range(0, 100);
				return longint'({$urandom(), $urandom()} >> 1) % len;
			end
		endcase
	endfunction

	task automatic randomize_mixer();
		logic [STEP_W-1:0] step;
		logic [LEN_W-1:0]  len;
		// Most settings ramp fast enough that the blend settles within a burst.
		case ($urandom_range(9))
			0: step = '0;
			1: step = STEP_W'($urandom_range(65537, 131071));
			2: step = STEP_W'($urandom_range(1, 300));
			default: step = STEP_W'($urandom_range(2048, 65536));
		endcase
		case ($urandom_range(9))
			0: len = '0;
			1: len = LEN_W'({$urandom(), $urandom()});
			2: len = '1;
			default: len = LEN_W'($urandom_range(1, 300));
		endcase
		set_mixer(random_gain(), random_gain(), step, len);
	endtask

	// Every register is written with random upper bits and with all ones,
	// and read back.
	task automatic test_register_access();
		logic [APB_DATA_W-1:0] got;
		logic [REG_IDX_W-1:0]  idx;
		for (int i = 0; i < 4; i++) begin
			idx = REG_IDX_W'(i);
			for (int pass = 0; pass < 2; pass++) begin
				write_register(idx, pass == 0 ? {$urandom(), $urandom()} : '1);
				read_register(idx, got);
				if (got !== register_value(idx))
					report_mismatch($sformatf("register %0d read %0h, expected %0h",
						idx, got, register_value(idx)));
			end
		end
	endtask

	// Hand-picked frames: song edges, positions at both ends of the field,
	// full-scale samples with maximum gain, a zero step, a step above one,
	// an empty song and a one-frame song.
	task automatic test_directed_frames();
		// Step above one acts as a full step, so the blend jumps at once.
		set_mixer('1, '1, '1, 4);
		send_frame(make_frame(0, 1'b1, S_MAX, S_MIN, S_MIN, S_MAX));
		send_frame(make_frame(1, 1'b1, S_MIN, S_MAX, S_MAX, S_MIN));
		send_frame(make_frame(2, 1'b1, S_MAX, S_MAX, S_MAX, S_MAX));
		send_frame(make_frame(3, 1'b1, S_MIN, S_MIN, S_MIN, S_MIN));
		send_frame(make_frame(4, 1'b1, S_MAX, S_MIN, '0, '0));
		send_frame(make_frame(-1, 1'b1, '0, '0, S_MAX, S_MIN));
		send_frame(make_frame(POS_MIN, 1'b0, S_MIN, S_MAX, S_MAX, S_MIN));
		send_frame(make_frame(POS_MAX, 1'b1, S_MAX, S_MIN, S_MIN, S_MAX));
		send_frame(make_frame(1, 1'b0, S_MAX, S_MIN, '0, '0));
		// A zero step creeps by one, over the longest song there is.
		set_mixer('0, 18'd65536, '0, LEN_W'(LEN_MAX));
		send_frame(random_frame(LEN_MAX - 1, 1'b1));
		send_frame(random_frame(0, 1'b1));
		send_frame(random_frame(64'sd1 <<< 39, 1'b1));
		send_frame(random_frame(LEN_MAX, 1'b1));
		send_frame(random_frame(12345, 1'b0));
		// An empty song keeps every frame out of range.
		set_mixer(rabxf_pkg::A_GAIN_RST, rabxf_pkg::B_GAIN_RST, 17'd65536, '0);
		send_frame(random_frame(0, 1'b1));
		send_frame(random_frame(5, 1'b1));
		send_frame(random_frame(-1, 1'b0));
		// A one-frame song with the smallest real step.
		set_mixer(rabxf_pkg::A_GAIN_RST, rabxf_pkg::B_GAIN_RST, 17'd1, 1);
		send_frame(random_frame(0, 1'b1));
		send_frame(random_frame(0, 1'b1));
		send_frame(random_frame(1, 1'b0));
	endtask

	// Mostly runs of consecutive frames walking through the song with a mostly
	// steady selection, so the blend can settle and lock; the rest is noise
	// over the whole position range. A new mixer setting about every hundred
	// frames.
	task automatic test_random_traffic(int send_pct, int recv_pct, int frame_total);
		int     sent;
		int     seg_sent;
		int     burst_len;
		longint pos;
		logic   sel;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < frame_total) begin
			randomize_mixer();
			seg_sent = 0;
			while (seg_sent < 100 && sent + seg_sent < frame_total) begin
				if ($urandom_range(99) < 80) begin
					burst_len = $urandom_range(10, 60);
					pos = burst_start();
					sel = 1'($urandom_range(1));
					repeat (burst_len) begin
						if ($urandom_range(99) < 5) sel = ~sel;
						send_frame(random_frame(pos, sel));
						pos++;
					end
				end else begin
					burst_len = $urandom_range(1, 5);
					repeat (burst_len)
						send_frame(random_frame({$urandom(), $urandom()},
							1'($urandom_range(1))));
				end
				seg_sent += burst_len;
			end
			sent += seg_sent;
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering frames, so the output register and the sequencer both fill and
	// frame_in stalls. Then the sender waits for every result.
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_mixer(18'd98304, 18'd40000, 17'd8192, 100);
		@(posedge clk);
		-> start_hold;
		for (int i = 0; i < 12; i++)
			send_frame(random_frame(i + 2, 1'b1));
		wait_for_results();
	endtask

	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		frame_in_if.valid            = 1'b0;
		frame_in_if.source_position  = '0;
		frame_in_if.select_reference = 1'b0;
		frame_in_if.live_left        = '0;
		frame_in_if.live_right       = '0;
		frame_in_if.reference_left   = '0;
		frame_in_if.reference_right  = '0;
		mixer_cfg   = '{rabxf_pkg::A_GAIN_RST, rabxf_pkg::B_GAIN_RST,
			rabxf_pkg::FADE_STEP_RST, rabxf_pkg::SONG_LENGTH_RST};
		blend_level = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_directed_frames();
		test_random_traffic(20, 67, 400);
		test_output_backpressure();
		test_random_traffic(67, 20, 400);
		test_random_traffic(0, 0, 400);

		wait_for_results();
		// Any stray request would show up within one frame time.
		repeat (FRAME_CYCLES + 20) @(posedge clk);
		if (expected_mix_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_mix_q.size()));

		$display("Checked %0d of %0d frames (%0d locked) over %0d mixer settings,",
			results_checked, frames_accepted, locked_seen, settings_used);
		$display("with random idling on both sides and one long output stall, in %0d cycles.",
			cycle_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
